[hw/rtl/sit_pkg.sv]
// package: shared types, codes and constants of the sensor id table
`default_nettype none
package sit_pkg;

  localparam int NODE_COUNT_DEF       = 8;
  localparam int ENTRIES_PER_NODE_DEF = 8;

  localparam int ID_W      = 48;
  localparam int READING_W = 16;
  localparam int NODE_W    = 3;
  localparam int SLOT_W    = 3;
  localparam int STATUS_W  = 3;
  // slot counter, holds up to eight entries plus the end value
  localparam int CNT_W     = 4;
  // wide enough for node * entries + slot at the largest sizes
  localparam int SUM_W     = 7;
  localparam int TOP_LSB   = 40;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_UPDATED  = 3'd0,
    STATUS_INSERTED = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_IGNORED  = 3'd3,
    STATUS_READ     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_RWAIT,
    CTL_DONE
  } ctl_state_t;

  typedef struct packed {
    status_t                status;
    logic [SLOT_W-1:0]      entry_index;
    logic [ID_W-1:0]        stored_id;
    logic [READING_W-1:0]   stored_reading;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/sit_mem.sv]
// table memory: id and reading per entry, valid bits give the zero reset
`default_nettype none
module sit_mem #(
  parameter int DEPTH = sit_pkg::NODE_COUNT_DEF * sit_pkg::ENTRIES_PER_NODE_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            wr_en,
  input  wire  [AW-1:0]                  wr_addr,
  input  wire  [sit_pkg::ID_W-1:0]       wr_id,
  input  wire  [sit_pkg::READING_W-1:0]  wr_reading,
  input  wire                            rd_en,
  input  wire  [AW-1:0]                  rd_addr,
  output logic [sit_pkg::ID_W-1:0]       rd_id,
  output logic [sit_pkg::READING_W-1:0]  rd_reading
);

  logic [sit_pkg::ID_W-1:0]      id_mem      [DEPTH];
  logic [sit_pkg::READING_W-1:0] reading_mem [DEPTH];
  logic [DEPTH-1:0]              valid;

  logic [sit_pkg::ID_W-1:0]      rd_id_raw;
  logic [sit_pkg::READING_W-1:0] rd_reading_raw;
  logic                          rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]      <= wr_id;
      reading_mem[wr_addr] <= wr_reading;
    end
    if (rd_en) begin
      rd_id_raw      <= id_mem[rd_addr];
      rd_reading_raw <= reading_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // never written entries read as zero
  assign rd_id      = rd_valid ? rd_id_raw : '0;
  assign rd_reading = rd_valid ? rd_reading_raw : '0;

endmodule
`default_nettype wire

[hw/rtl/sit_ctrl.sv]
// controller: scans a node's entries one per cycle, writes unless full
`default_nettype none
module sit_ctrl #(
  parameter int NODE_COUNT       = sit_pkg::NODE_COUNT_DEF,
  parameter int ENTRIES_PER_NODE = sit_pkg::ENTRIES_PER_NODE_DEF,
  parameter int AW = (NODE_COUNT * ENTRIES_PER_NODE > 1) ?
                     $clog2(NODE_COUNT * ENTRIES_PER_NODE) : 1
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            op,
  input  wire  [sit_pkg::NODE_W-1:0]     node,
  input  wire  [sit_pkg::SLOT_W-1:0]     slot,
  input  wire  [sit_pkg::ID_W-1:0]       device_id,
  input  wire  [sit_pkg::READING_W-1:0]  reading,
  output logic                           res_valid,
  input  wire                            res_ready,
  output sit_pkg::result_t               res,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [sit_pkg::ID_W-1:0]       wr_id,
  output logic [sit_pkg::READING_W-1:0]  wr_reading,
  output logic                           rd_en,
  output logic [AW-1:0]                  rd_addr,
  input  wire  [sit_pkg::ID_W-1:0]       rd_id,
  input  wire  [sit_pkg::READING_W-1:0]  rd_reading
);

  sit_pkg::ctl_state_t state, state_next;
  sit_pkg::result_t    res_next;

  logic [sit_pkg::SUM_W-1:0]     base, base_next;
  logic [sit_pkg::ID_W-1:0]      id, id_next;
  logic [sit_pkg::READING_W-1:0] rdg, rdg_next;
  logic [sit_pkg::CNT_W-1:0]     cnt, cnt_next;
  logic                          dv, dv_next;
  logic [sit_pkg::SLOT_W-1:0]    dslot, dslot_next;
  logic                          hit, hit_next;
  logic [sit_pkg::SLOT_W-1:0]    hit_slot, hit_slot_next;
  logic                          fre, fre_next;
  logic [sit_pkg::SLOT_W-1:0]    free_slot, free_slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sit_pkg::CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res       <= res_next;
    base      <= base_next;
    id        <= id_next;
    rdg       <= rdg_next;
    cnt       <= cnt_next;
    dv        <= dv_next;
    dslot     <= dslot_next;
    hit       <= hit_next;
    hit_slot  <= hit_slot_next;
    fre       <= fre_next;
    free_slot <= free_slot_next;
  end

  always_comb begin
    logic [sit_pkg::SUM_W-1:0] acc_base;
    logic [sit_pkg::SUM_W-1:0] sum;
    logic                      cur_free;
    logic                      cur_hit;
    logic                      h, f;
    logic [sit_pkg::SLOT_W-1:0] hs, fs;

    state_next     = state;
    res_next       = res;
    base_next      = base;
    id_next        = id;
    rdg_next       = rdg;
    cnt_next       = cnt;
    dv_next        = 1'b0;
    dslot_next     = dslot;
    hit_next       = hit;
    hit_slot_next  = hit_slot;
    fre_next       = fre;
    free_slot_next = free_slot;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_id          = id;
    wr_reading     = rdg;
    rd_en          = 1'b0;
    rd_addr        = '0;

    acc_base = sit_pkg::SUM_W'(node) * sit_pkg::SUM_W'(ENTRIES_PER_NODE);
    sum      = '0;
    cur_free = ~|rd_id[sit_pkg::ID_W-1:sit_pkg::TOP_LSB];
    cur_hit  = !cur_free && (rd_id == id);
    h  = hit | cur_hit;
    hs = hit ? hit_slot : dslot;
    f  = fre | cur_free;
    fs = fre ? free_slot : dslot;

    case (state)
      sit_pkg::CTL_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          base_next = acc_base;
          id_next   = device_id;
          rdg_next  = reading;
          if (({1'b0, node} >= (sit_pkg::NODE_W+1)'(NODE_COUNT)) ||
              (op && ({1'b0, slot} >= (sit_pkg::SLOT_W+1)'(ENTRIES_PER_NODE)))) begin
            res_next = '{status: sit_pkg::STATUS_IGNORED, entry_index: '0,
                         stored_id: '0, stored_reading: '0};
            state_next = sit_pkg::CTL_DONE;
          end else if (op) begin
            sum      = acc_base + sit_pkg::SUM_W'(slot);
            rd_en    = 1'b1;
            rd_addr  = sum[AW-1:0];
            res_next.entry_index = slot;
            state_next = sit_pkg::CTL_RWAIT;
          end else begin
            cnt_next = '0;
            hit_next = 1'b0;
            fre_next = 1'b0;
            state_next = sit_pkg::CTL_SCAN;
          end
        end
      end

      sit_pkg::CTL_SCAN: begin
        // issue the next slot while the previous one's data is checked
        if (cnt < sit_pkg::CNT_W'(ENTRIES_PER_NODE)) begin
          sum        = base + sit_pkg::SUM_W'(cnt);
          rd_en      = 1'b1;
          rd_addr    = sum[AW-1:0];
          cnt_next   = cnt + 1'b1;
          dv_next    = 1'b1;
          dslot_next = cnt[sit_pkg::SLOT_W-1:0];
        end
        if (dv) begin
          hit_next       = h;
          hit_slot_next  = hs;
          fre_next       = f;
          free_slot_next = fs;
          if (dslot == sit_pkg::SLOT_W'(ENTRIES_PER_NODE - 1)) begin
            state_next = sit_pkg::CTL_DONE;
            if (h) begin
              sum      = base + sit_pkg::SUM_W'(hs);
              wr_en    = 1'b1;
              wr_addr  = sum[AW-1:0];
              res_next = '{status: sit_pkg::STATUS_UPDATED, entry_index: hs,
                           stored_id: id, stored_reading: rdg};
            end else if (f) begin
              sum      = base + sit_pkg::SUM_W'(fs);
              wr_en    = 1'b1;
              wr_addr  = sum[AW-1:0];
              res_next = '{status: sit_pkg::STATUS_INSERTED, entry_index: fs,
                           stored_id: id, stored_reading: rdg};
            end else begin
              res_next = '{status: sit_pkg::STATUS_FULL, entry_index: '0,
                           stored_id: '0, stored_reading: '0};
            end
          end
        end
      end

      sit_pkg::CTL_RWAIT: begin
        res_next.status         = sit_pkg::STATUS_READ;
        res_next.stored_id      = rd_id;
        res_next.stored_reading = rd_reading;
        state_next = sit_pkg::CTL_DONE;
      end

      sit_pkg::CTL_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = sit_pkg::CTL_IDLE;
        end
      end

      default: begin
        state_next = sit_pkg::CTL_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/sensor_id_table_update.sv]
// an ignored item goes straight to its result, a read item reads its one entry, and an update
// item scans every entry of its node; the scan reads one entry per cycle from the table memory
// items are taken one at a time, each only once the last is finished; the next item is
// taken while a finished result still sits in the output register
// reset: synchronous active-high rst clears control state and the entry valid bits,
// so every entry reads as zero (free) right after reset, with no clearing pass
`default_nettype none
module sensor_id_table_update #(
  parameter int NODE_COUNT       = sit_pkg::NODE_COUNT_DEF,
  parameter int ENTRIES_PER_NODE = sit_pkg::ENTRIES_PER_NODE_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            op,
  input  wire  [sit_pkg::NODE_W-1:0]     node,
  input  wire  [sit_pkg::SLOT_W-1:0]     slot,
  input  wire  [sit_pkg::ID_W-1:0]       device_id,
  input  wire  [sit_pkg::READING_W-1:0]  reading,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [sit_pkg::STATUS_W-1:0]   status,
  output logic [sit_pkg::SLOT_W-1:0]     entry_index,
  output logic [sit_pkg::ID_W-1:0]       stored_id,
  output logic [sit_pkg::READING_W-1:0]  stored_reading
);

  // one entry per (node, slot), at node * ENTRIES_PER_NODE + slot
  localparam int DEPTH = NODE_COUNT * ENTRIES_PER_NODE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // memory port wires
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [sit_pkg::ID_W-1:0]      wr_id;
  logic [sit_pkg::READING_W-1:0] wr_reading;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [sit_pkg::ID_W-1:0]      rd_id;
  logic [sit_pkg::READING_W-1:0] rd_reading;

  // finished result from the controller
  logic             res_valid;
  logic             res_ready;
  sit_pkg::result_t res;

  // output register
  sit_pkg::result_t out_q;

  sit_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_id      (wr_id),
    .wr_reading (wr_reading),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_id      (rd_id),
    .rd_reading (rd_reading)
  );

  sit_ctrl #(
    .NODE_COUNT       (NODE_COUNT),
    .ENTRIES_PER_NODE (ENTRIES_PER_NODE),
    .AW               (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .node       (node),
    .slot       (slot),
    .device_id  (device_id),
    .reading    (reading),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_id      (wr_id),
    .wr_reading (wr_reading),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_id      (rd_id),
    .rd_reading (rd_reading)
  );

  // the output register frees the controller as soon as a result is handed over
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign status         = out_q.status;
  assign entry_index    = out_q.entry_index;
  assign stored_id      = out_q.stored_id;
  assign stored_reading = out_q.stored_reading;

endmodule
`default_nettype wire

[hw/rtl/sit_checker.sv]
// checker: port-level assertions for the sensor id table, bound to the top level
`default_nettype none
module sit_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [sit_pkg::STATUS_W-1:0]    status,
  input wire [sit_pkg::SLOT_W-1:0]      entry_index,
  input wire [sit_pkg::ID_W-1:0]        stored_id,
  input wire [sit_pkg::READING_W-1:0]   stored_reading
);

  // a waiting result's status and id stay put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(stored_id))
    else $error("result dropped or changed while stalled");

  // one item at a time: the input side closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  // ignored items and full results carry all-zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sit_pkg::STATUS_IGNORED || status == sit_pkg::STATUS_FULL)
    |-> entry_index == '0 && stored_id == '0 && stored_reading == '0)
    else $error("nonzero fields on ignored or full result");

  // a matched entry is always occupied
  a_hit_occupied: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sit_pkg::STATUS_UPDATED
    |-> stored_id[sit_pkg::ID_W-1:sit_pkg::TOP_LSB] != '0)
    else $error("update matched a free entry");

endmodule

bind sensor_id_table_update sit_checker u_sit_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .entry_index    (entry_index),
  .stored_id      (stored_id),
  .stored_reading (stored_reading)
);
`default_nettype wire
